@@ sv/stb_pkg.sv @@
// Shared types, codes and helpers for the scrolling text terminal buffer.
package stb_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_DOT   = 7'h2E;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CHAR,
        OP_NEWLINE,
        OP_RETURN,
        OP_HEX,
        OP_READ,
        OP_READ_NULL,
        OP_CLEAR
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLANK,
        ST_HEX,
        ST_PUT,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [3:0] row;
        logic [5:0] col;
    } t_req;

    function automatic logic [6:0] hex_digit(input logic [3:0] n);
        logic [6:0] w;
        w = {3'b000, n};
        if (n < 4'd10) begin
            return 7'h30 + w;
        end
        return 7'h37 + w;
    endfunction

endpackage

@@ sv/scrolling_text_terminal_buffer.sv @@
// Top level of the scrolling text terminal buffer.
// Usage:
//   Requests enter on i_in_valid/o_in_ready with i_command, i_data_byte,
//   i_row_index and i_column_index; each request gives exactly one result on
//   o_out_valid/i_out_ready with cell char, head row, cursor and hex count.
//   i_cfg_we/i_cfg_data set hex mode; write it only while the block is idle.
//   A two-entry queue sits between request decode and the execution engine.
//   After acceptance, carriage return, unused command, out-of-range read
//   and a hex byte that does not complete a group go straight to the
//   result; read and plain character first pass a read or put state;
//   newline and clear blank the head row one cell per cycle through the
//   single store write port; a wrapping character blanks the new row and
//   then writes; a completed hex group writes its row, then blanks the next.
//   Rows scroll by rotating a base pointer; no stored text moves.
//   After reset the control registers are cleared and row 0 is blanked;
//   requests are queued meanwhile and executed afterwards.
//   A stalled receiver holds the result register; the engine then holds its
//   next finished result and the queue takes up to two more requests.
module scrolling_text_terminal_buffer #(
    parameter int LINES       = 16,
    parameter int LINE_LENGTH = 41,
    parameter int HEX_GROUP   = 13
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_data_byte,
    input  logic [3:0] i_row_index,
    input  logic [5:0] i_column_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_cell_char,
    output logic [3:0] o_head_row,
    output logic [5:0] o_cursor_col,
    output logic [3:0] o_hex_pending
);

    stb_pkg::t_req push_req;
    stb_pkg::t_req q_req;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    stb_front #(
        .LINES       (LINES),
        .LINE_LENGTH (LINE_LENGTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_data_byte    (i_data_byte),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .o_push         (push),
        .o_req          (push_req),
        .i_full         (q_full)
    );

    stb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (pop)
    );

    stb_back #(
        .LINES       (LINES),
        .LINE_LENGTH (LINE_LENGTH),
        .HEX_GROUP   (HEX_GROUP)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_req       (q_req),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cell_char   (o_cell_char),
        .o_head_row    (o_head_row),
        .o_cursor_col  (o_cursor_col),
        .o_hex_pending (o_hex_pending)
    );

`ifndef NO_ASSERTIONS
    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_head_row) < LINES) || (LINES > 16))
        else $error("head row beyond store");

    a_cursor_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_cursor_col) <= LINE_LENGTH - 2) || (LINE_LENGTH > 65))
        else $error("cursor beyond last text column");

    a_hex_below_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_hex_pending) < HEX_GROUP) || (HEX_GROUP > 15))
        else $error("hex group not flushed");

    a_ready_when_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_full |-> o_in_ready)
        else $error("request refused with queue space");
`endif

endmodule

@@ sv/stb_front.sv @@
// Front end: accepts requests, holds the mode register and classifies commands.
module stb_front #(
    parameter int LINES       = 16,
    parameter int LINE_LENGTH = 41
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_command,
    input  logic [7:0]    i_data_byte,
    input  logic [3:0]    i_row_index,
    input  logic [5:0]    i_column_index,
    output logic          o_push,
    output stb_pkg::t_req o_req,
    input  logic          i_full
);

    localparam int COLS = LINE_LENGTH - 1;

    logic       r_hex_mode;
    logic       row_ok;
    logic       col_ok;
    logic [6:0] shown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_hex_mode <= i_cfg_data;
        end
    end

    assign row_ok = 32'(i_row_index) < 32'(LINES);
    assign col_ok = 32'(i_column_index) < 32'(COLS);
    assign shown  = (i_data_byte >= stb_pkg::PRINT_LO && i_data_byte <= stb_pkg::PRINT_HI) ?
                    i_data_byte[6:0] : stb_pkg::CHAR_DOT;

    always_comb begin
        o_req.data = i_data_byte;
        o_req.row  = i_row_index;
        o_req.col  = i_column_index;
        case (i_command)
            stb_pkg::CMD_WRITE: begin
                if (r_hex_mode) begin
                    o_req.op = stb_pkg::OP_HEX;
                end else if (i_data_byte == stb_pkg::BYTE_LF) begin
                    o_req.op = stb_pkg::OP_NEWLINE;
                end else if (i_data_byte == stb_pkg::BYTE_CR) begin
                    o_req.op = stb_pkg::OP_RETURN;
                end else begin
                    o_req.op   = stb_pkg::OP_CHAR;
                    o_req.data = {1'b0, shown};
                end
            end
            stb_pkg::CMD_READ: begin
                o_req.op = (row_ok && col_ok) ? stb_pkg::OP_READ : stb_pkg::OP_READ_NULL;
            end
            stb_pkg::CMD_CLEAR: begin
                o_req.op = stb_pkg::OP_CLEAR;
            end
            default: begin
                o_req.op = stb_pkg::OP_NOP;
            end
        endcase
    end

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

@@ sv/stb_queue.sv @@
// Short request queue between the front end and the back end.
module stb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stb_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_valid,
    output stb_pkg::t_req o_req,
    input  logic          i_pop
);

    localparam int PTR_W = (stb_pkg::QUEUE_DEPTH > 1) ? $clog2(stb_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(stb_pkg::QUEUE_DEPTH + 1);

    stb_pkg::t_req    r_entry [stb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(stb_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_req   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(stb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(stb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/stb_back.sv @@
// Back end: text store, row rotation, hex grouping and the result register.
module stb_back #(
    parameter int LINES       = 16,
    parameter int LINE_LENGTH = 41,
    parameter int HEX_GROUP   = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  stb_pkg::t_req i_q_req,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [6:0]    o_cell_char,
    output logic [3:0]    o_head_row,
    output logic [5:0]    o_cursor_col,
    output logic [3:0]    o_hex_pending
);

    localparam int COLS      = LINE_LENGTH - 1;
    localparam int ROW_W     = $clog2(LINES);
    localparam int COL_W     = $clog2(COLS);
    localparam int FILL_W    = $clog2(HEX_GROUP + 1);
    localparam int GRP_W     = (HEX_GROUP > 1) ? $clog2(HEX_GROUP) : 1;
    localparam int MEM_DEPTH = LINES << COL_W;
    localparam int HEX_FIT   = (LINE_LENGTH - 2) / 3;
    localparam int HEX_N     = (HEX_GROUP < HEX_FIT) ? HEX_GROUP : HEX_FIT;
    localparam int HEX_COLS  = 3 * HEX_N;

    stb_pkg::t_state r_state, n_state;
    stb_pkg::t_req   r_req, n_req;
    logic [ROW_W-1:0]  r_base, n_base;
    logic [ROW_W-1:0]  r_head, n_head;
    logic [ROW_W-1:0]  r_head_phys, n_head_phys;
    logic [ROW_W-1:0]  r_blank_row, n_blank_row;
    logic [COL_W-1:0]  r_cursor, n_cursor;
    logic [COL_W-1:0]  r_cnt, n_cnt;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [GRP_W-1:0]  r_grp, n_grp;
    logic [1:0]        r_phase, n_phase;
    logic              r_put, n_put;
    logic              r_silent, n_silent;
    logic [LINES-1:0]  r_row_valid, n_row_valid;
    logic [6:0]        r_cell, n_cell;
    logic              r_out_valid, n_out_valid;
    logic [6:0]        r_o_cell, n_o_cell;
    logic [3:0]        r_o_head, n_o_head;
    logic [5:0]        r_o_cursor, n_o_cursor;
    logic [3:0]        r_o_pending, n_o_pending;

    logic [6:0]              r_mem [MEM_DEPTH];
    logic [6:0]              r_rd_data;
    logic                    r_rd_valid;
    logic                    mem_we;
    logic [ROW_W+COL_W-1:0]  mem_waddr;
    logic [6:0]              mem_wdata;
    logic                    mem_re;
    logic [ROW_W-1:0]        rd_row;
    logic [7:0]              r_group [HEX_GROUP];
    logic                    grp_we;

    logic             sr_last;
    logic [ROW_W-1:0] sr_head;
    logic [ROW_W-1:0] sr_base;
    logic [ROW_W-1:0] sr_phys;
    logic [FILL_W-1:0] fill_inc;
    logic [7:0]       grp_byte;
    logic [6:0]       hex_char;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] b,
                                                  input logic [ROW_W-1:0] r);
        logic [ROW_W:0] s;
        s = {1'b0, b} + {1'b0, r};
        if (s >= (ROW_W+1)'(LINES)) begin
            s = s - (ROW_W+1)'(LINES);
        end
        return s[ROW_W-1:0];
    endfunction

    assign sr_last  = r_head == ROW_W'(LINES - 1);
    assign sr_head  = sr_last ? r_head : r_head + 1'b1;
    assign sr_base  = sr_last ? phys_row(r_base, ROW_W'(1)) : r_base;
    assign sr_phys  = phys_row(sr_base, sr_head);
    assign fill_inc = (r_fill < FILL_W'(HEX_GROUP)) ? r_fill + 1'b1 : r_fill;
    assign grp_byte = r_group[r_grp];
    assign rd_row   = phys_row(r_base, ROW_W'(i_q_req.row));

    always_comb begin
        case (r_phase)
            2'd0:    hex_char = stb_pkg::hex_digit(grp_byte[7:4]);
            2'd1:    hex_char = stb_pkg::hex_digit(grp_byte[3:0]);
            default: hex_char = stb_pkg::CHAR_SPACE;
        endcase
        if (r_cnt >= COL_W'(HEX_COLS)) begin
            hex_char = stb_pkg::CHAR_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stb_pkg::ST_BLANK;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_base      = r_base;
        n_head      = r_head;
        n_head_phys = r_head_phys;
        n_blank_row = r_blank_row;
        n_cursor    = r_cursor;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_grp       = r_grp;
        n_phase     = r_phase;
        n_put       = r_put;
        n_silent    = r_silent;
        n_row_valid = r_row_valid;
        n_cell      = r_cell;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_cell    = r_o_cell;
        n_o_head    = r_o_head;
        n_o_cursor  = r_o_cursor;
        n_o_pending = r_o_pending;
        mem_we      = 1'b0;
        mem_waddr   = {r_head_phys, r_cursor};
        mem_wdata   = stb_pkg::CHAR_SPACE;
        mem_re      = 1'b0;
        grp_we      = 1'b0;
        o_pop       = 1'b0;

        case (r_state)
            stb_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_req  = i_q_req;
                    n_cell = '0;
                    case (i_q_req.op)
                        stb_pkg::OP_CHAR: begin
                            if (r_cursor >= COL_W'(LINE_LENGTH - 2)) begin
                                n_head      = sr_head;
                                n_base      = sr_base;
                                n_head_phys = sr_phys;
                                n_blank_row = sr_phys;
                                n_cursor    = '0;
                                n_cnt       = '0;
                                n_put       = 1'b1;
                                n_silent    = 1'b0;
                                n_state     = stb_pkg::ST_BLANK;
                            end else begin
                                n_state = stb_pkg::ST_PUT;
                            end
                        end
                        stb_pkg::OP_NEWLINE: begin
                            n_head      = sr_head;
                            n_base      = sr_base;
                            n_head_phys = sr_phys;
                            n_blank_row = sr_phys;
                            n_cursor    = '0;
                            n_cnt       = '0;
                            n_put       = 1'b0;
                            n_silent    = 1'b0;
                            n_state     = stb_pkg::ST_BLANK;
                        end
                        stb_pkg::OP_RETURN: begin
                            n_cursor = '0;
                            n_state  = stb_pkg::ST_DONE;
                        end
                        stb_pkg::OP_HEX: begin
                            grp_we = r_fill < FILL_W'(HEX_GROUP);
                            n_fill = fill_inc;
                            if (fill_inc >= FILL_W'(HEX_GROUP)) begin
                                n_cnt   = '0;
                                n_grp   = '0;
                                n_phase = 2'd0;
                                n_state = stb_pkg::ST_HEX;
                            end else begin
                                n_state = stb_pkg::ST_DONE;
                            end
                        end
                        stb_pkg::OP_READ: begin
                            mem_re  = 1'b1;
                            n_state = stb_pkg::ST_READ;
                        end
                        stb_pkg::OP_CLEAR: begin
                            n_base      = '0;
                            n_head      = '0;
                            n_head_phys = '0;
                            n_blank_row = '0;
                            n_cursor    = '0;
                            n_fill      = '0;
                            n_row_valid = '0;
                            n_cnt       = '0;
                            n_put       = 1'b0;
                            n_silent    = 1'b0;
                            n_state     = stb_pkg::ST_BLANK;
                        end
                        default: begin
                            n_state = stb_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            stb_pkg::ST_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = {r_blank_row, r_cnt};
                mem_wdata = stb_pkg::CHAR_SPACE;
                if (r_cnt == COL_W'(COLS - 1)) begin
                    n_row_valid[r_blank_row] = 1'b1;
                    if (r_put) begin
                        n_state = stb_pkg::ST_PUT;
                    end else if (r_silent) begin
                        n_state = stb_pkg::ST_IDLE;
                    end else begin
                        n_state = stb_pkg::ST_DONE;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            stb_pkg::ST_HEX: begin
                mem_we    = 1'b1;
                mem_waddr = {r_head_phys, r_cnt};
                mem_wdata = hex_char;
                if (r_phase == 2'd2) begin
                    n_phase = 2'd0;
                    if (r_grp != GRP_W'(HEX_GROUP - 1)) begin
                        n_grp = r_grp + 1'b1;
                    end
                end else begin
                    n_phase = r_phase + 1'b1;
                end
                if (r_cnt == COL_W'(COLS - 1)) begin
                    n_head      = sr_head;
                    n_base      = sr_base;
                    n_head_phys = sr_phys;
                    n_blank_row = sr_phys;
                    n_cursor    = '0;
                    n_fill      = '0;
                    n_cnt       = '0;
                    n_put       = 1'b0;
                    n_silent    = 1'b0;
                    n_state     = stb_pkg::ST_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            stb_pkg::ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = {r_head_phys, r_cursor};
                mem_wdata = r_req.data[6:0];
                n_cursor  = r_cursor + 1'b1;
                n_state   = stb_pkg::ST_DONE;
            end
            stb_pkg::ST_READ: begin
                n_cell  = r_rd_valid ? r_rd_data : stb_pkg::CHAR_SPACE;
                n_state = stb_pkg::ST_DONE;
            end
            stb_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_cell    = r_cell;
                    n_o_head    = 4'(r_head);
                    n_o_cursor  = 6'(r_cursor);
                    n_o_pending = 4'(r_fill);
                    n_state     = stb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_head      <= '0;
            r_head_phys <= '0;
            r_blank_row <= '0;
            r_cursor    <= '0;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_grp       <= '0;
            r_phase     <= 2'd0;
            r_put       <= 1'b0;
            r_silent    <= 1'b1;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_base      <= n_base;
            r_head      <= n_head;
            r_head_phys <= n_head_phys;
            r_blank_row <= n_blank_row;
            r_cursor    <= n_cursor;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_grp       <= n_grp;
            r_phase     <= n_phase;
            r_put       <= n_put;
            r_silent    <= n_silent;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_cell      <= n_cell;
        r_o_cell    <= n_o_cell;
        r_o_head    <= n_o_head;
        r_o_cursor  <= n_o_cursor;
        r_o_pending <= n_o_pending;
    end

    always_ff @(posedge i_clk) begin
        if (grp_we) begin
            r_group[r_fill[GRP_W-1:0]] <= i_q_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data  <= r_mem[{rd_row, COL_W'(i_q_req.col)}];
            r_rd_valid <= r_row_valid[rd_row];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_char   = r_o_cell;
    assign o_head_row    = r_o_head;
    assign o_cursor_col  = r_o_cursor;
    assign o_hex_pending = r_o_pending;

endmodule
